[sv/lafsi_pkg.sv]
// Package with the shared constants, types and register indexes of the LMS system identifier.
`default_nettype none

package lafsi_pkg;

	localparam int DEF_FIXED_TAPS = 64;
	localparam int DEF_ADAPT_TAPS = 64;

	localparam int KIND_W   = 1;
	localparam int INDEX_W  = 6;
	localparam int SAMPLE_W = 16;
	localparam int WGT_W    = 32;
	localparam int PROD_W   = WGT_W + SAMPLE_W;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;
	localparam int SHIFT_W    = 6;

	localparam logic [CFG_IDX_W-1:0] REG_STEP_SHIFT    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_SELECT = CFG_IDX_W'(1);

	localparam logic [SHIFT_W-1:0] STEP_SHIFT_RESET = SHIFT_W'(11);

	localparam logic KIND_LOAD   = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WRITE,
		ST_FIX,
		ST_ADAPT,
		ST_DRAIN_MAC,
		ST_ERR,
		ST_UPD,
		ST_DRAIN_UPD,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		TAG_FIX,
		TAG_ADAPT,
		TAG_UPD
	} tag_t;

endpackage

`default_nettype wire

[sv/lafsi_if.sv]
// Valid/ready channel interfaces for the input items and the result items.
`default_nettype none

interface lafsi_in_if;
	import lafsi_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [KIND_W-1:0]          kind;
	logic [INDEX_W-1:0]         coef_index;
	logic signed [SAMPLE_W-1:0] coef_value;
	logic signed [SAMPLE_W-1:0] noise_sample;

	modport source (output valid, output kind, output coef_index, output coef_value,
		output noise_sample, input ready);
	modport sink (input valid, input kind, input coef_index, input coef_value,
		input noise_sample, output ready);
endinterface

interface lafsi_out_if;
	import lafsi_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] filter_out;
	logic signed [SAMPLE_W-1:0] error_out;

	modport source (output valid, output filter_out, output error_out, input ready);
	modport sink (input valid, input filter_out, input error_out, output ready);
endinterface

`default_nettype wire

[sv/lafsi_ram.sv]
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module lafsi_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[sv/lms_adaptive_fir_system_id_top.sv]
// Top level of the LMS adaptive FIR system identifier with its shared multiply unit.
//
// Usage: sample_in takes words of two kinds. A load word (kind 0) writes one Q15
// coefficient of the fixed filter and leaves the block idle; it gives no result.
// A sample word (kind 1) shifts noise_sample into the delay line, runs the fixed and
// the adaptive FIR, forms the error and updates every adaptive weight. Its result word,
// the selected filter output and the error, leaves on result_out.
// One signed 32x16 multiplier behind a pipeline walks all tap operations:
// FIXED_TAPS products for the fixed sum, ADAPT_TAPS for the adaptive sum and ADAPT_TAPS
// weight updates. sample_in.ready is low while a sample word is worked on.
// Reset clears the delay line and the weights through per-entry valid bits, so no
// clearing pass is needed; the fixed coefficients must be loaded before use.
// step_shift resets to 11 and output_select to 0; cfg_we writes one of them.
// result_out holds its word while the receiver stalls. The next word is still taken,
// but a finished sample waits until the held result has been taken.
`default_nettype none

module lms_adaptive_fir_system_id_top #(
	parameter int FIXED_TAPS = lafsi_pkg::DEF_FIXED_TAPS,
	parameter int ADAPT_TAPS = lafsi_pkg::DEF_ADAPT_TAPS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	lafsi_in_if.sink                             sample_in,
	lafsi_out_if.source                          result_out,
	input  wire logic                            cfg_we,
	input  wire logic [lafsi_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [lafsi_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lafsi_pkg::*;

	localparam int TMAX  = (FIXED_TAPS > ADAPT_TAPS) ? FIXED_TAPS : ADAPT_TAPS;
	localparam int DAW   = (TMAX > 1) ? $clog2(TMAX) : 1;
	localparam int CAW   = (FIXED_TAPS > 1) ? $clog2(FIXED_TAPS) : 1;
	localparam int WAW   = (ADAPT_TAPS > 1) ? $clog2(ADAPT_TAPS) : 1;
	localparam int ACC_W = PROD_W + DAW + 1;

	// Configuration registers.
	logic [SHIFT_W-1:0] step_q;
	logic               sel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_SHIFT_RESET;
			sel_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STEP_SHIFT:    step_q <= cfg_data[SHIFT_W-1:0];
				REG_OUTPUT_SELECT: sel_q  <= cfg_data[0];
				default:           ;
			endcase
		end
	end

	// Sequencer state.
	state_t          state_q, state_d;
	logic [DAW-1:0]  cnt_q;
	logic [DAW-1:0]  wp_q;
	logic [DAW-1:0]  wp_next;
	logic [TMAX-1:0] dvalid_q;
	logic [ADAPT_TAPS-1:0] wvalid_q;
	logic signed [SAMPLE_W-1:0] x_q;

	logic in_acc;
	logic out_free;
	logic pipe_empty;
	logic last_fix, last_adapt;

	// Outputs of the sequencer.
	logic in_ready;
	logic iss_v;
	tag_t iss_tag;
	logic dly_we;
	logic acc_clr;
	logic err_ld;
	logic out_ld;

	// Pipeline registers.
	logic           v_s1, v_s2;
	tag_t           tag_s1, tag_s2;
	logic [WAW-1:0] wa_s1, wa_s2;
	logic           dval_s1, wval_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [WGT_W-1:0]  w_s2;

	logic signed [ACC_W-1:0] acc_fix_q, acc_ad_q;
	logic signed [SAMPLE_W-1:0] err_q, fout_q;
	logic signed [SAMPLE_W-1:0] out_fout_q, out_err_q;
	logic out_valid_q;

	assign in_acc     = sample_in.valid && in_ready;
	assign out_free   = !out_valid_q || result_out.ready;
	assign pipe_empty = !v_s1 && !v_s2;
	assign last_fix   = (cnt_q == DAW'(FIXED_TAPS - 1));
	assign last_adapt = (cnt_q == DAW'(ADAPT_TAPS - 1));
	assign wp_next    = (wp_q == DAW'(TMAX - 1)) ? '0 : wp_q + DAW'(1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && sample_in.kind == KIND_SAMPLE) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE:     state_d = ST_FIX;
			ST_FIX: begin
				if (last_fix) begin
					state_d = ST_ADAPT;
				end
			end
			ST_ADAPT: begin
				if (last_adapt) begin
					state_d = ST_DRAIN_MAC;
				end
			end
			ST_DRAIN_MAC: begin
				if (pipe_empty) begin
					state_d = ST_ERR;
				end
			end
			ST_ERR:       state_d = ST_UPD;
			ST_UPD: begin
				if (last_adapt) begin
					state_d = ST_DRAIN_UPD;
				end
			end
			ST_DRAIN_UPD: begin
				if (pipe_empty) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		iss_v    = 1'b0;
		iss_tag  = TAG_FIX;
		dly_we   = 1'b0;
		acc_clr  = 1'b0;
		err_ld   = 1'b0;
		out_ld   = 1'b0;
		case (state_q)
			ST_IDLE:  in_ready = 1'b1;
			ST_WRITE: begin
				dly_we  = 1'b1;
				acc_clr = 1'b1;
			end
			ST_FIX: begin
				iss_v   = 1'b1;
				iss_tag = TAG_FIX;
			end
			ST_ADAPT: begin
				iss_v   = 1'b1;
				iss_tag = TAG_ADAPT;
			end
			ST_ERR:   err_ld = 1'b1;
			ST_UPD: begin
				iss_v   = 1'b1;
				iss_tag = TAG_UPD;
			end
			ST_OUT:   out_ld = out_free;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			wp_q     <= '0;
			dvalid_q <= '0;
		end else begin
			state_q <= state_d;
			if (iss_v && !((iss_tag == TAG_FIX) ? last_fix : last_adapt)) begin
				cnt_q <= cnt_q + DAW'(1);
			end else begin
				cnt_q <= '0;
			end
			if (dly_we) begin
				wp_q              <= wp_next;
				dvalid_q[wp_next] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q <= sample_in.noise_sample;
		end
	end

	// Tap i of the delay line sits i entries behind the newest sample.
	logic [DAW-1:0] d_raddr;
	logic [DAW:0]   d_back;

	always_comb begin
		if ({1'b0, wp_q} >= {1'b0, cnt_q}) begin
			d_back = {1'b0, wp_q} - {1'b0, cnt_q};
		end else begin
			d_back = {1'b0, wp_q} + (DAW + 1)'(TMAX) - {1'b0, cnt_q};
		end
		d_raddr = d_back[DAW-1:0];
	end

	// Memories.
	logic                 coef_we;
	logic [SAMPLE_W-1:0]  coef_rd;
	logic [SAMPLE_W-1:0]  dly_rd;
	logic [WGT_W-1:0]     w_rd;
	logic                 w_we;
	logic [WGT_W-1:0]     w_wdata;

	assign coef_we = in_acc && (sample_in.kind == KIND_LOAD) &&
		(32'(sample_in.coef_index) < 32'(FIXED_TAPS));

	lafsi_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(FIXED_TAPS)
	) u_coef_ram (
		.clk  (clk),
		.we   (coef_we),
		.waddr(CAW'(sample_in.coef_index)),
		.wdata(sample_in.coef_value),
		.raddr(cnt_q[CAW-1:0]),
		.rdata(coef_rd)
	);

	lafsi_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(TMAX)
	) u_delay_ram (
		.clk  (clk),
		.we   (dly_we),
		.waddr(wp_next),
		.wdata(x_q),
		.raddr(d_raddr),
		.rdata(dly_rd)
	);

	lafsi_ram #(
		.WIDTH(WGT_W),
		.DEPTH(ADAPT_TAPS)
	) u_weight_ram (
		.clk  (clk),
		.we   (w_we),
		.waddr(wa_s2),
		.wdata(w_wdata),
		.raddr(cnt_q[WAW-1:0]),
		.rdata(w_rd)
	);

	// Stage 1: read data arrives; pick the multiplier operands.
	logic signed [WGT_W-1:0]    opa;
	logic signed [WGT_W-1:0]    w_cur;
	logic signed [SAMPLE_W-1:0] tap;

	assign w_cur = wval_s1 ? $signed(w_rd) : '0;
	assign tap   = dval_s1 ? $signed(dly_rd) : '0;

	always_comb begin
		case (tag_s1)
			TAG_FIX:   opa = WGT_W'($signed(coef_rd));
			TAG_ADAPT: opa = w_cur;
			TAG_UPD:   opa = WGT_W'(err_q);
			default:   opa = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= iss_v;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1  <= iss_tag;
		wa_s1   <= cnt_q[WAW-1:0];
		dval_s1 <= dvalid_q[d_raddr];
		wval_s1 <= wvalid_q[cnt_q[WAW-1:0]];
		tag_s2  <= tag_s1;
		wa_s2   <= wa_s1;
		prod_s2 <= opa * tap;
		w_s2    <= w_cur;
	end

	// Stage 2: accumulate, or form the updated weight and write it back.
	logic signed [PROD_W-1:0] upd_d;
	logic signed [WGT_W:0]    upd_sum;

	assign upd_d   = prod_s2 >>> step_q;
	assign upd_sum = (WGT_W + 1)'(w_s2) + $signed(upd_d[WGT_W:0]);
	assign w_we    = v_s2 && (tag_s2 == TAG_UPD);

	always_comb begin
		if (upd_sum[WGT_W] != upd_sum[WGT_W-1]) begin
			w_wdata = upd_sum[WGT_W] ? {1'b1, {(WGT_W - 1){1'b0}}} : {1'b0, {(WGT_W - 1){1'b1}}};
		end else begin
			w_wdata = upd_sum[WGT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wvalid_q <= '0;
		end else if (w_we) begin
			wvalid_q[wa_s2] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_clr) begin
			acc_fix_q <= '0;
			acc_ad_q  <= '0;
		end else if (v_s2) begin
			if (tag_s2 == TAG_FIX) begin
				acc_fix_q <= acc_fix_q + ACC_W'(prod_s2);
			end
			if (tag_s2 == TAG_ADAPT) begin
				acc_ad_q <= acc_ad_q + ACC_W'(prod_s2);
			end
		end
	end

	// Output scaling; arithmetic shifts give the floor of the division.
	logic signed [ACC_W-1:0] fix_sh, ad_sh, sel_sh;
	logic signed [ACC_W:0]   diff;
	logic signed [SAMPLE_W-1:0] err_sat, fout_sat;

	assign fix_sh = acc_fix_q >>> 15;
	assign ad_sh  = acc_ad_q >>> 30;
	assign sel_sh = sel_q ? fix_sh : ad_sh;
	assign diff   = (ACC_W + 1)'(fix_sh) - (ACC_W + 1)'(ad_sh);

	always_comb begin
		if (&diff[ACC_W:SAMPLE_W-1] || ~|diff[ACC_W:SAMPLE_W-1]) begin
			err_sat = diff[SAMPLE_W-1:0];
		end else begin
			err_sat = diff[ACC_W] ? {1'b1, {(SAMPLE_W - 1){1'b0}}} : {1'b0, {(SAMPLE_W - 1){1'b1}}};
		end
		if (&sel_sh[ACC_W-1:SAMPLE_W-1] || ~|sel_sh[ACC_W-1:SAMPLE_W-1]) begin
			fout_sat = sel_sh[SAMPLE_W-1:0];
		end else begin
			fout_sat = sel_sh[ACC_W-1] ? {1'b1, {(SAMPLE_W - 1){1'b0}}} :
				{1'b0, {(SAMPLE_W - 1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (err_ld) begin
			err_q  <= err_sat;
			fout_q <= fout_sat;
		end
		if (out_ld) begin
			out_fout_q <= fout_q;
			out_err_q  <= err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ld) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sample_in.ready       = in_ready;
	assign result_out.valid      = out_valid_q;
	assign result_out.filter_out = out_fout_q;
	assign result_out.error_out  = out_err_q;

endmodule

`default_nettype wire

[sv/lafsi_checker.sv]
// Port-level assertions for the LMS system identifier and the bind that attaches them.
`default_nettype none

module lafsi_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        in_kind,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] filter_out,
	input wire logic [15:0] error_out
);

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	// A stalled result word keeps its valid and its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(filter_out) && $stable(error_out))
		else $error("result word changed while stalled");

	// A sample word occupies the block, so the next word is not taken at once.
	a_busy_after_sample: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_kind |=> !in_ready)
		else $error("input ready right after a sample word");

	// No result word appears in the cycle after any input word is taken.
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !$rose(out_valid))
		else $error("result word appeared too early");

	// A new result word is only produced while the input side was held off.
	a_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result word produced while idle");

endmodule

bind lms_adaptive_fir_system_id_top lafsi_checker u_lafsi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample_in.valid),
	.in_ready  (sample_in.ready),
	.in_kind   (sample_in.kind),
	.out_valid (result_out.valid),
	.out_ready (result_out.ready),
	.filter_out(result_out.filter_out),
	.error_out (result_out.error_out)
);

`default_nettype wire

[verif/lms_adaptive_fir_system_id_top_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the LMS system identifier: random traffic and a built-in predictor.
module lms_adaptive_fir_system_id_top_tb;
	import lafsi_pkg::*;

	localparam int FIXED_TAPS    = DEF_FIXED_TAPS;
	localparam int ADAPT_TAPS    = DEF_ADAPT_TAPS;
	localparam int LINE_LEN      = (FIXED_TAPS > ADAPT_TAPS) ? FIXED_TAPS : ADAPT_TAPS;
	localparam int SETTLE_CYCLES = FIXED_TAPS + 2 * ADAPT_TAPS + 50;
	localparam int CYCLE_LIMIT   = 2000000;
	localparam int PRINT_LIMIT   = 200;

	localparam longint OUT_MIN = -32768;
	localparam longint OUT_MAX = 32767;
	localparam longint WGT_MIN = -(longint'(1) <<< 31);
	localparam longint WGT_MAX = (longint'(1) <<< 31) - 1;

	typedef struct packed {
		logic [KIND_W-1:0]          kind;
		logic [INDEX_W-1:0]         coef_index;
		logic signed [SAMPLE_W-1:0] coef_value;
		logic signed [SAMPLE_W-1:0] noise_sample;
	} in_word_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] filter_val;
		logic signed [SAMPLE_W-1:0] error_val;
	} result_word_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	lafsi_in_if  sample_if();
	lafsi_out_if result_if();

	lms_adaptive_fir_system_id_top #(
		.FIXED_TAPS(FIXED_TAPS),
		.ADAPT_TAPS(ADAPT_TAPS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_in(sample_if),
		.result_out(result_if),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Predictor state: its own copy of the registers, coefficients, delay line and weights.
	logic [SHIFT_W-1:0]         model_shift;
	logic                       model_select;
	logic signed [SAMPLE_W-1:0] coef_mem [FIXED_TAPS];
	logic signed [SAMPLE_W-1:0] tap_line [LINE_LEN];
	logic signed [WGT_W-1:0]    weight_mem [ADAPT_TAPS];

	in_word_t     stim_words[$];
	result_word_t predicted_results[$];

	int error_count;
	int cycle_count;
	bit in_taken;
	int tx_idle;
	int tx_quiet;
	int rx_stall;
	int rx_quiet;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic longint sat_range(longint v, longint lo, longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Shift in the sample, form both FIR sums, then move every weight by the LMS step.
	function automatic result_word_t lms_predict(logic signed [SAMPLE_W-1:0] x);
		longint       fix_acc;
		longint       ad_acc;
		longint       fix_y;
		longint       ad_y;
		longint       err;
		longint       upd;
		result_word_t r;
		fix_acc = 0;
		ad_acc = 0;
		for (int i = LINE_LEN - 1; i > 0; i--)
			tap_line[i] = tap_line[i - 1];
		tap_line[0] = x;
		for (int i = 0; i < FIXED_TAPS; i++)
			fix_acc += longint'(coef_mem[i]) * longint'(tap_line[i]);
		for (int i = 0; i < ADAPT_TAPS; i++)
			ad_acc += longint'(weight_mem[i]) * longint'(tap_line[i]);
		// Arithmetic shifts of signed values round toward minus infinity.
		fix_y = fix_acc >>> 15;
		ad_y = ad_acc >>> 30;
		err = sat_range(fix_y - ad_y, OUT_MIN, OUT_MAX);
		for (int i = 0; i < ADAPT_TAPS; i++) begin
			upd = longint'(weight_mem[i]) + ((err * longint'(tap_line[i])) >>> model_shift);
			weight_mem[i] = WGT_W'(sat_range(upd, WGT_MIN, WGT_MAX));
		end
		r.filter_val = SAMPLE_W'(sat_range(model_select ? fix_y : ad_y, OUT_MIN, OUT_MAX));
		r.error_val = SAMPLE_W'(err);
		return r;
	endfunction

	task automatic report_mismatch(string what, longint want, longint got);
		error_count++;
		if (error_count <= PRINT_LIMIT)
			$display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
	endtask

	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 4);
		if (r < 96)
			return $urandom_range(5, 30);
		return $urandom_range(100, 300);
	endfunction

	function automatic int sender_gap();
		if (tx_quiet > 0) begin
			tx_quiet--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0)
			tx_quiet = $urandom_range(8, 40);
		return idle_length();
	endfunction

	// Driver and receiver: everything the block sees changes at the falling edge.
	always @(negedge clk) begin
		in_word_t w;
		logic     next_valid;
		if (arst_n) begin
			next_valid = sample_if.valid;
			if (!sample_if.valid || in_taken) begin
				next_valid = 1'b0;
				if (tx_idle > 0) begin
					tx_idle--;
				end else if (stim_words.size() > 0) begin
					w = stim_words.pop_front();
					next_valid = 1'b1;
					sample_if.kind <= w.kind;
					sample_if.coef_index <= w.coef_index;
					sample_if.coef_value <= w.coef_value;
					sample_if.noise_sample <= w.noise_sample;
					tx_idle = sender_gap();
				end
			end
			sample_if.valid <= next_valid;

			if (rx_stall > 0) begin
				rx_stall--;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= 1'b1;
				if (rx_quiet > 0)
					rx_quiet--;
				else if ($urandom_range(0, 99) == 0)
					rx_quiet = $urandom_range(300, 1500);
				else if ($urandom_range(0, 2) == 0)
					rx_stall = idle_length();
			end
		end
	end

	// Monitor: follows register writes and accepted words, and checks every result word.
	always @(posedge clk) begin
		result_word_t want;
		in_taken = sample_if.valid && sample_if.ready;
		if (arst_n) begin
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("lms_adaptive_fir_system_id_top test failed");
				$finish;
			end else begin
				if (cfg_we) begin
					case (cfg_index)
						REG_STEP_SHIFT:    model_shift = cfg_data[SHIFT_W-1:0];
						REG_OUTPUT_SELECT: model_select = cfg_data[0];
						default: ;
					endcase
				end
				if (in_taken) begin
					if (sample_if.kind == KIND_LOAD) begin
						if (sample_if.coef_index < FIXED_TAPS)
							coef_mem[sample_if.coef_index] = sample_if.coef_value;
					end else begin
						predicted_results.push_back(lms_predict(sample_if.noise_sample));
					end
				end
				if (result_if.valid && result_if.ready) begin
					if (predicted_results.size() == 0) begin
						report_mismatch("result word with none pending", 0, result_if.filter_out);
					end else begin
						want = predicted_results.pop_front();
						if (result_if.filter_out !== want.filter_val)
							report_mismatch("filter_out", want.filter_val, result_if.filter_out);
						if (result_if.error_out !== want.error_val)
							report_mismatch("error_out", want.error_val, result_if.error_out);
					end
				end
			end
		end
	end

	task automatic push_load(int idx, int val);
		in_word_t w;
		w.kind = KIND_LOAD;
		w.coef_index = INDEX_W'(idx);
		w.coef_value = SAMPLE_W'(val);
		w.noise_sample = SAMPLE_W'($urandom);
		stim_words.push_back(w);
	endtask

	task automatic push_sample(int val);
		in_word_t w;
		w.kind = KIND_SAMPLE;
		w.coef_index = INDEX_W'($urandom);
		w.coef_value = SAMPLE_W'($urandom);
		w.noise_sample = SAMPLE_W'(val);
		stim_words.push_back(w);
	endtask

	function automatic int random_noise(int small_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < 6) begin
			case ($urandom_range(0, 3))
				0:       return 32767;
				1:       return -32768;
				2:       return 0;
				default: return -1;
			endcase
		end
		if (r < 6 + small_pct)
			return int'($urandom_range(0, 1023)) - 512;
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	// Waits until every word went in and every result came out, then lets the block go idle.
	task automatic settle();
		while (stim_words.size() != 0 || sample_if.valid || predicted_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(val);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(int shift, int sel);
		write_reg(REG_STEP_SHIFT, shift);
		write_reg(REG_OUTPUT_SELECT, sel);
	endtask

	// Mostly sample words, with coefficient reloads mixed in.
	task automatic run_random(int count, int small_pct);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 99) < 12)
				push_load($urandom_range(0, 63), int'($urandom_range(0, 65535)) - 32768);
			else
				push_sample(random_noise(small_pct));
		end
		settle();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sample_if.valid = 1'b0;
		sample_if.kind = KIND_LOAD;
		sample_if.coef_index = '0;
		sample_if.coef_value = '0;
		sample_if.noise_sample = '0;
		result_if.ready = 1'b0;
		model_shift = STEP_SHIFT_RESET;
		model_select = 1'b0;
		for (int i = 0; i < FIXED_TAPS; i++)
			coef_mem[i] = '0;
		for (int i = 0; i < LINE_LEN; i++)
			tap_line[i] = '0;
		for (int i = 0; i < ADAPT_TAPS; i++)
			weight_mem[i] = '0;
		error_count = 0;
		cycle_count = 0;
		in_taken = 1'b0;
		tx_idle = 0;
		tx_quiet = 0;
		rx_stall = 0;
		rx_quiet = 0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Every coefficient is loaded before the first sample, at the extremes of the range.
		push_load(0, 32767);
		for (int i = 1; i < FIXED_TAPS; i++)
			push_load(i, -32768);
		// Full-scale samples drive the fixed sum far past the output range.
		push_sample(32767);
		push_sample(32767);
		push_sample(32767);
		push_sample(-32768);
		push_sample(-32768);
		push_sample(-32768);
		push_sample(0);
		push_sample(-1);
		push_sample(1);
		// A load ignores its sample field and a sample ignores the coefficient fields.
		push_load(5, 12345);
		push_sample(random_noise(0));
		push_load(63, 32767);
		push_sample(random_noise(0));
		settle();

		// A step of zero saturates the weights.
		set_config(0, 1);
		run_random(50, 10);
		set_config(63, 0);
		run_random(50, 30);
		set_config(47, 1);
		for (int i = 0; i < FIXED_TAPS; i++)
			push_load(i, int'($urandom_range(0, 65535)) - 32768);
		run_random(40, 20);
		repeat (3) begin
			set_config($urandom_range(4, 16), $urandom_range(0, 1));
			run_random(40, $urandom_range(0, 50));
		end

		if (error_count == 0)
			$display("lms_adaptive_fir_system_id_top test passed");
		else
			$display("lms_adaptive_fir_system_id_top test failed");
		$finish;
	end

endmodule

[files.f]
sv/lafsi_pkg.sv
sv/lafsi_if.sv
sv/lafsi_ram.sv
sv/lms_adaptive_fir_system_id_top.sv
sv/lafsi_checker.sv
verif/lms_adaptive_fir_system_id_top_tb.sv
